/* hw/rtl/assert_macros.svh */
// Assertion macros for the load protection and fan monitor RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising aclk edge outside reset.
`define LPFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising aclk edge, reset included.
`define LPFM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/lpfm_pkg.sv */
// Types and constants for the load protection and fan monitor.
// No dependencies; imported by load_protection_and_fan_monitor_unit.
package lpfm_pkg;

    localparam int TEMP_CODE_BITS = 12;

    localparam int V_W    = 16;
    localparam int I_W    = 15;
    localparam int CODE_W = 12;
    localparam int TEN_W  = 11;
    localparam int SCL_W  = 16;
    localparam int CFG_W  = 20;
    localparam int IDX_W  = 3;
    localparam int P_W    = V_W + I_W;
    localparam int TP_W   = TEMP_CODE_BITS + SCL_W;
    localparam int IN_W   = 48;
    localparam int OUT_W  = 16;

    localparam int MUL_STEPS = V_W;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    localparam logic [TEN_W-1:0] HOT_TENTHS = 11'd400;
    localparam logic [TEN_W-1:0] TEMP_MAX   = 11'd1500;
    localparam logic [TEN_W-1:0] LIM_KNEE   = 11'd250;
    localparam logic [16:0]      HOT_MAX    = 17'd131071;
    localparam logic [15:0]      TICK_MAX   = 16'd65535;

    // Four times the per-device derating limit, in microwatts.
    localparam logic [29:0] LIM4_MAX   = 30'd856000000;
    localparam logic [29:0] LIM4_BASE  = 30'd996000000;
    localparam logic [19:0] LIM4_SLOPE = 20'd560000;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_VOLTAGE  = 3'd0,
        REG_CURRENT_CUT  = 3'd1,
        REG_POWER_CUT    = 3'd2,
        REG_TEMP_CUT     = 3'd3,
        REG_INTERVAL     = 3'd4,
        REG_FAN_HOLD     = 3'd5,
        REG_TEMP_SCALE   = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        TRIP_NONE    = 3'd0,
        TRIP_VOLTAGE = 3'd1,
        TRIP_CURRENT = 3'd2,
        TRIP_POWER   = 3'd3,
        TRIP_TEMP    = 3'd4,
        TRIP_DISS    = 3'd5
    } trip_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_TEMP,
        ST_LIM,
        ST_CMP
    } state_t;

endpackage

/* hw/rtl/load_protection_and_fan_monitor_unit.sv */
// Channel    | Dir | Fields (tdata, lowest bit first)
// s_ (tick)  | in  | voltage_mv[15:0] current_ma[30:16] temp_code[42:31], zero pad
// m_ (status)| out | trip_code[2:0] fan_on[3] temperature_tenths[14:4] temp_updated[15]
// cfg_       | in  | cfg_index selects register, cfg_wdata value, cfg_we strobe
//
// m_tvalid rises after a tick transfer once the bit-serial V*I and code*scale
// multipliers, then the timer/fan, limit and compare steps have run. A new tick
// is taken only after the unit returns to idle, not while one is in flight.
// Synchronous active-low reset restores register defaults and clears timers.
// A finished result sits in the output register; the next tick is taken while
// it waits, and the compare step stalls only until that register is free.
// Depends on lpfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module load_protection_and_fan_monitor_unit
    import lpfm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // voltage_mv, current_ma, temp_code, pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // trip_code, fan_on, temperature_tenths, temp_updated
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    state_t state_reg, state_next;

    logic [V_W-1:0]   maxv_reg;
    logic [I_W-1:0]   ccut_reg;
    logic [CFG_W-1:0] pcut_reg;
    logic [TEN_W-1:0] tcut_reg;
    logic [15:0]      interval_reg;
    logic [15:0]      hold_reg;
    logic [SCL_W-1:0] scale_reg;

    logic [15:0]      tick_reg;
    logic [16:0]      hot_reg;
    logic             fan_reg;
    logic [TEN_W-1:0] temp_reg;
    logic             upd_reg;

    logic [STEP_W-1:0] step_reg;
    logic [P_W-1:0]    pv_reg;
    logic [TP_W-1:0]   tp_reg;
    logic [V_W-1:0]    v_reg;
    logic [I_W-1:0]    i_reg;

    logic [29:0] lim4_reg, lim4_next;
    logic [21:0] i100_reg, i100_next;
    logic [21:0] c101_reg, c101_next;
    logic [29:0] p1000_reg, p1000_next;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic in_ready, mul_en, tick_en, lim_en, cmp_en, out_free, accept;

    logic [15:0]      code_wide;
    logic [I_W:0]     pv_sum;
    logic [SCL_W:0]   tp_sum;
    logic             tp_step;
    logic [TP_W-9:0]  t_raw;
    logic [TEN_W-1:0] t_sat;
    logic [16:0]      hot_inc;
    logic [15:0]      tick_inc;
    logic             check;
    logic [29:0]      lim_prod;
    trip_t            trip_next;

    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && in_ready;
    assign s_tready = in_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MUL;
            ST_MUL:  if (step_reg == STEP_W'(MUL_STEPS - 1)) state_next = ST_TEMP;
            ST_TEMP: state_next = ST_LIM;
            ST_LIM:  state_next = ST_CMP;
            ST_CMP:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        in_ready = 1'b0;
        mul_en   = 1'b0;
        tick_en  = 1'b0;
        lim_en   = 1'b0;
        cmp_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_MUL:  mul_en   = 1'b1;
            ST_TEMP: tick_en  = 1'b1;
            ST_LIM:  lim_en   = 1'b1;
            ST_CMP:  cmp_en   = out_free;
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maxv_reg     <= 16'd55000;
            ccut_reg     <= 15'd16000;
            pcut_reg     <= 20'd200000;
            tcut_reg     <= 11'd800;
            interval_reg <= 16'd1000;
            hold_reg     <= 16'd10000;
            scale_reg    <= 16'd256;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_MAX_VOLTAGE: maxv_reg     <= cfg_wdata[V_W-1:0];
                REG_CURRENT_CUT: ccut_reg     <= cfg_wdata[I_W-1:0];
                REG_POWER_CUT:   pcut_reg     <= cfg_wdata;
                REG_TEMP_CUT:    tcut_reg     <= cfg_wdata[TEN_W-1:0];
                REG_INTERVAL:    interval_reg <= cfg_wdata[15:0];
                REG_FAN_HOLD:    hold_reg     <= cfg_wdata[15:0];
                REG_TEMP_SCALE:  scale_reg    <= cfg_wdata[SCL_W-1:0];
                default: ;
            endcase
        end
    end

    // bit-serial multipliers: V*I over 16 steps, code*scale over the code bits
    assign code_wide = {4'b0, s_tdata[V_W+I_W +: CODE_W]};
    assign pv_sum    = {1'b0, pv_reg[P_W-1:V_W]} + {1'b0, i_reg};
    assign tp_sum    = {1'b0, tp_reg[TP_W-1:TEMP_CODE_BITS]} + {1'b0, scale_reg};
    assign tp_step   = {1'b0, step_reg} < (STEP_W + 1)'(TEMP_CODE_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (accept) begin
            step_reg <= '0;
        end else if (mul_en) begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            v_reg  <= s_tdata[V_W-1:0];
            i_reg  <= s_tdata[V_W +: I_W];
            pv_reg <= {{I_W{1'b0}}, s_tdata[V_W-1:0]};
            tp_reg <= {{SCL_W{1'b0}}, code_wide[TEMP_CODE_BITS-1:0]};
        end else if (mul_en) begin
            pv_reg <= pv_reg[0] ? {pv_sum, pv_reg[V_W-1:1]} : {1'b0, pv_reg[P_W-1:1]};
            if (tp_step) begin
                tp_reg <= tp_reg[0] ? {tp_sum, tp_reg[TEMP_CODE_BITS-1:1]}
                                    : {1'b0, tp_reg[TP_W-1:1]};
            end
        end
    end

    // timers, temperature and fan
    assign t_raw    = tp_reg[TP_W-1:8];
    assign t_sat    = (t_raw > (TP_W - 8)'(TEMP_MAX)) ? TEMP_MAX : t_raw[TEN_W-1:0];
    assign hot_inc  = (hot_reg != HOT_MAX) ? hot_reg + 17'd1 : hot_reg;
    assign tick_inc = (tick_reg != TICK_MAX) ? tick_reg + 16'd1 : tick_reg;
    assign check    = tick_inc >= interval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            hot_reg  <= '0;
            fan_reg  <= 1'b0;
            temp_reg <= '0;
            upd_reg  <= 1'b0;
        end else if (tick_en) begin
            upd_reg <= check;
            if (check) begin
                tick_reg <= '0;
                temp_reg <= t_sat;
                if (t_sat >= HOT_TENTHS) begin
                    fan_reg <= 1'b1;
                    hot_reg <= '0;
                end else begin
                    hot_reg <= hot_inc;
                    if (fan_reg && hot_inc >= {1'b0, hold_reg}) fan_reg <= 1'b0;
                end
            end else begin
                tick_reg <= tick_inc;
                hot_reg  <= hot_inc;
            end
        end
    end

    // trip thresholds
    assign lim_prod   = {10'b0, LIM4_SLOPE} * {19'b0, temp_reg};
    assign lim4_next  = (temp_reg < LIM_KNEE) ? LIM4_MAX : LIM4_BASE - lim_prod;
    assign i100_next  = {7'b0, i_reg} * 22'd100;
    assign c101_next  = {7'b0, ccut_reg} * 22'd101;
    assign p1000_next = {10'b0, pcut_reg} * 30'd1000;

    always_ff @(posedge aclk) begin
        if (lim_en) begin
            lim4_reg  <= lim4_next;
            i100_reg  <= i100_next;
            c101_reg  <= c101_next;
            p1000_reg <= p1000_next;
        end
    end

    // priority trip check
    always_comb begin
        if (v_reg > maxv_reg)                    trip_next = TRIP_VOLTAGE;
        else if (i100_reg > c101_reg)            trip_next = TRIP_CURRENT;
        else if (pv_reg > {1'b0, p1000_reg})     trip_next = TRIP_POWER;
        else if (temp_reg > tcut_reg)            trip_next = TRIP_TEMP;
        else if (pv_reg >= {1'b0, lim4_reg})     trip_next = TRIP_DISS;
        else                                     trip_next = TRIP_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmp_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_en) m_data_reg <= {upd_reg, temp_reg, fan_reg, trip_next};
    end

    `LPFM_ASSERT(a_fan_on_at_check, $rose(fan_reg) |-> upd_reg, "fan turned on without a check")
    `LPFM_ASSERT(a_accept_starts_mul, accept |=> (state_reg == ST_MUL && step_reg == '0),
        "transfer did not start the multiplier")
    `LPFM_ASSERT_ALWAYS(a_temp_range, (!aresetn || temp_reg <= TEMP_MAX), "temperature above saturation")

endmodule
